[src/ulm_pkg.sv]
// Package for the lowercase mapper: widths and the code point mapping function.
// No dependencies; used by ulm_core and unicode_lowercase_mapper.
package ulm_pkg;

  localparam int CpW = 21;
  typedef logic [CpW-1:0] cp_t;

  function automatic logic in_rng(input cp_t c, input cp_t lo, input cp_t hi);
    in_rng = (c >= lo) && (c <= hi);
  endfunction

  function automatic cp_t even_up(input cp_t c);
    cp_t t;
    t = c + 21'd1;
    even_up = {t[CpW-1:1], 1'b0};
  endfunction

  // Explicit exception pairs; anything else maps to itself
  function automatic cp_t pair_lookup(input cp_t c);
    cp_t r;
    r = c;
    unique case (c)
      21'h178: r = 21'h0FF;  21'h181: r = 21'h253;  21'h182: r = 21'h183;
      21'h184: r = 21'h185;  21'h186: r = 21'h254;  21'h187: r = 21'h188;
      21'h189: r = 21'h256;  21'h18A: r = 21'h257;  21'h18B: r = 21'h18C;
      21'h18E: r = 21'h1DD;  21'h18F: r = 21'h259;  21'h190: r = 21'h25B;
      21'h191: r = 21'h192;  21'h193: r = 21'h260;  21'h194: r = 21'h263;
      21'h196: r = 21'h269;  21'h197: r = 21'h268;  21'h198: r = 21'h199;
      21'h19C: r = 21'h26F;  21'h19D: r = 21'h272;  21'h19F: r = 21'h275;
      21'h1A6: r = 21'h280;  21'h1A7: r = 21'h1A8;  21'h1A9: r = 21'h283;
      21'h1AC: r = 21'h1AD;  21'h1AE: r = 21'h288;  21'h1AF: r = 21'h1B0;
      21'h1B1: r = 21'h28A;  21'h1B2: r = 21'h28B;  21'h1B7: r = 21'h292;
      21'h1B8: r = 21'h1B9;  21'h1BC: r = 21'h1BD;  21'h1C4: r = 21'h1C6;
      21'h1C5: r = 21'h1C6;  21'h1C7: r = 21'h1C9;  21'h1C8: r = 21'h1C9;
      21'h1CA: r = 21'h1CC;  21'h1CB: r = 21'h1CC;  21'h1CD: r = 21'h1CE;
      21'h1F1: r = 21'h1F3;  21'h1F2: r = 21'h1F3;  21'h1F4: r = 21'h1F5;
      21'h1F6: r = 21'h195;  21'h1F7: r = 21'h1BF;
      21'h220: r = 21'h19E;  21'h23A: r = 21'h2C65; 21'h23B: r = 21'h23C;
      21'h23D: r = 21'h19A;  21'h23E: r = 21'h2C66; 21'h241: r = 21'h242;
      21'h243: r = 21'h180;  21'h244: r = 21'h289;  21'h245: r = 21'h28C;
      21'h37F: r = 21'h3F3;  21'h386: r = 21'h3AC;  21'h388: r = 21'h3AD;
      21'h389: r = 21'h3AE;  21'h38A: r = 21'h3AF;  21'h38C: r = 21'h3CC;
      21'h38E: r = 21'h3CD;  21'h38F: r = 21'h3CE;  21'h3CF: r = 21'h3D7;
      21'h3F4: r = 21'h3B8;  21'h3F7: r = 21'h3F8;  21'h3F9: r = 21'h3F2;
      21'h3FA: r = 21'h3FB;  21'h3FD: r = 21'h37B;  21'h3FE: r = 21'h37C;
      21'h3FF: r = 21'h37D;  21'h4C0: r = 21'h4CF;
      21'h1FB8: r = 21'h1FB0; 21'h1FB9: r = 21'h1FB1; 21'h1FBA: r = 21'h1F70;
      21'h1FBB: r = 21'h1F71; 21'h1FBC: r = 21'h1FB3; 21'h1FC8: r = 21'h1F72;
      21'h1FC9: r = 21'h1F73; 21'h1FCA: r = 21'h1F74; 21'h1FCB: r = 21'h1F75;
      21'h1FCC: r = 21'h1FC3; 21'h1FD8: r = 21'h1FD0; 21'h1FD9: r = 21'h1FD1;
      21'h1FDA: r = 21'h1F76; 21'h1FDB: r = 21'h1F77; 21'h1FE8: r = 21'h1FE0;
      21'h1FE9: r = 21'h1FE1; 21'h1FEA: r = 21'h1F7A; 21'h1FEB: r = 21'h1F7B;
      21'h1FEC: r = 21'h1FE5; 21'h1FF8: r = 21'h1F78; 21'h1FF9: r = 21'h1F79;
      21'h1FFA: r = 21'h1F7C; 21'h1FFB: r = 21'h1F7D; 21'h1FFC: r = 21'h1FF3;
      21'h2126: r = 21'h3C9;  21'h212A: r = 21'h06B;  21'h212B: r = 21'h0E5;
      21'h2132: r = 21'h214E; 21'h2183: r = 21'h2184;
      21'h2C62: r = 21'h26B;  21'h2C63: r = 21'h1D7D; 21'h2C64: r = 21'h27D;
      21'h2C6D: r = 21'h251;  21'h2C6E: r = 21'h271;  21'h2C6F: r = 21'h250;
      21'h2C70: r = 21'h252;  21'h2C7E: r = 21'h23F;  21'h2C7F: r = 21'h240;
      21'hA77D: r = 21'h1D79; 21'hA78B: r = 21'hA78C; 21'hA78D: r = 21'h265;
      21'hA7AA: r = 21'h266;  21'hA7AB: r = 21'h25C;  21'hA7AC: r = 21'h261;
      21'hA7AD: r = 21'h26C;  21'hA7AE: r = 21'h26A;  21'hA7B0: r = 21'h29E;
      21'hA7B1: r = 21'h287;  21'hA7B2: r = 21'h29D;  21'hA7B3: r = 21'hAB53;
      default: r = c;
    endcase
    pair_lookup = r;
  endfunction

endpackage

[src/ulm_core.sv]
// Combinational lowercase mapping of one code point.
// Depends on ulm_pkg for the rule helpers and the exception pairs.
module ulm_core import ulm_pkg::*; (
  input  logic cp_in,
  input  cp_t  code_point,
  output cp_t  lower_code_point
);

  cp_t c;
  cp_t r;
  cp_t c1;
  assign c  = code_point;
  assign c1 = c | 21'd1;

  // Select the rule by block, in the order the ranges take precedence
  always_comb begin
    r = c;
    if (cp_in && c == 21'h49) r = 21'h131;
    else if (c == 21'h130) r = 21'h69;
    else if (c < 21'h100) begin
      if (in_rng(c, 21'h41, 21'h5A) || in_rng(c, 21'hC0, 21'hDE)) r = c + 21'h20;
    end else if (c < 21'h200) begin
      if (c < 21'h138 || in_rng(c, 21'h14A, 21'h177) || in_rng(c, 21'h1A0, 21'h1A5) ||
          in_rng(c, 21'h1DE, 21'h1EF) || c >= 21'h1F8) r = c1;
      else if (in_rng(c, 21'h139, 21'h148) || in_rng(c, 21'h179, 21'h17E) ||
               in_rng(c, 21'h1B3, 21'h1B6) || in_rng(c, 21'h1CF, 21'h1DC)) r = even_up(c);
      else r = pair_lookup(c);
    end else if (c < 21'h300) begin
      if (c < 21'h220 || in_rng(c, 21'h222, 21'h233) || in_rng(c, 21'h246, 21'h24F)) r = c1;
      else r = pair_lookup(c);
    end else if (c < 21'h400) begin
      if (c < 21'h370 || c[7:4] == 4'hB) r = c;
      else if (in_rng(c, 21'h370, 21'h373) || in_rng(c, 21'h376, 21'h377) ||
               in_rng(c, 21'h3D8, 21'h3EF)) r = c1;
      else if (in_rng(c, 21'h391, 21'h3A1) || in_rng(c, 21'h3A3, 21'h3AB)) r = c + 21'h20;
      else r = pair_lookup(c);
    end else if (c < 21'h500) begin
      if (c < 21'h410) r = c + 21'h50;
      else if (c < 21'h430) r = c + 21'h20;
      else if (in_rng(c, 21'h460, 21'h481) || in_rng(c, 21'h48A, 21'h4BF) || c >= 21'h4D0)
        r = c1;
      else if (in_rng(c, 21'h4C1, 21'h4CE)) r = even_up(c);
      else r = pair_lookup(c);
    end else if (c < 21'h600) begin
      if (c < 21'h530) r = c1;
      else if (in_rng(c, 21'h531, 21'h556)) r = c + 21'h30;
    end else if (c < 21'h10000) begin
      if (c[15:8] == 8'h10) begin
        if (in_rng(c, 21'h10A0, 21'h10C5) || c == 21'h10C7 || c == 21'h10CD)
          r = c + 21'h1C60;
      end else if (c[15:8] == 8'h13) begin
        if (in_rng(c, 21'h13A0, 21'h13EF)) r = c + 21'h97D0;
        else if (in_rng(c, 21'h13F0, 21'h13F5)) r = c | 21'd8;
      end else if (c[15:8] == 8'h1E) begin
        r = (c == 21'h1E9E) ? 21'hDF : c1;
      end else if (c[15:8] == 8'h1F) begin
        if (c < 21'h1F70 || in_rng(c, 21'h1F80, 21'h1FAF)) begin
          if (c == 21'h1F1E || c == 21'h1F1F || c == 21'h1F4E || c == 21'h1F4F ||
              c == 21'h1F58 || c == 21'h1F5A || c == 21'h1F5C || c == 21'h1F5E) r = c;
          else r = c & ~21'd8;
        end else r = pair_lookup(c);
      end else if (c[15:12] == 4'h2) begin
        if (c[15:8] == 8'h2C) begin
          if (c < 21'h2C2F) r = c + 21'h30;
          else if (in_rng(c, 21'h2C80, 21'h2CE3) || c == 21'h2CF2 || c == 21'h2C60 ||
                   c == 21'h2C72) r = c1;
          else if (in_rng(c, 21'h2C67, 21'h2C6C) || in_rng(c, 21'h2CEB, 21'h2CEE))
            r = even_up(c);
          else if (c == 21'h2C75) r = c + 21'd1;
          else r = pair_lookup(c);
        end else if (c[15:4] == 12'h216) r = c | 21'h10;
        else if (in_rng(c, 21'h24B6, 21'h24CF)) r = c + 21'd26;
        else r = pair_lookup(c);
      end else if (c[15:8] == 8'hA6) begin
        if (in_rng(c, 21'hA640, 21'hA66D) || in_rng(c, 21'hA680, 21'hA69B)) r = c1;
      end else if (c[15:8] == 8'hA7) begin
        if (in_rng(c, 21'hA722, 21'hA72F) || in_rng(c, 21'hA732, 21'hA76F) ||
            in_rng(c, 21'hA77E, 21'hA787) || in_rng(c, 21'hA790, 21'hA793) ||
            in_rng(c, 21'hA796, 21'hA7A9) || in_rng(c, 21'hA7B4, 21'hA7B7)) r = c1;
        else if (in_rng(c, 21'hA779, 21'hA77C)) r = even_up(c);
        else r = pair_lookup(c);
      end else if (c[15:12] == 4'hF) begin
        if (in_rng(c, 21'hFF21, 21'hFF3A)) r = c + 21'h20;
      end
    end else begin
      if (in_rng(c, 21'h10400, 21'h10427) || in_rng(c, 21'h104B0, 21'h104D3))
        r = c + 21'h28;
      else if (in_rng(c, 21'h10C80, 21'h10CB2)) r = c | 21'h40;
      else if (in_rng(c, 21'h118A0, 21'h118BF)) r = c + 21'h20;
      else if (in_rng(c, 21'h1E900, 21'h1E921)) r = c + 21'h22;
    end
  end

  assign lower_code_point = r;

endmodule

[src/unicode_lowercase_mapper.sv]
// Top level of the lowercase mapper: input register, mapping logic, output register.
// Depends on ulm_pkg and ulm_core.
//
// Usage:
//   s_axis carries one code point per item in s_axis_tdata[20:0]; m_axis returns
//   its lowercase form in m_axis_tdata[20:0]. One result per item, in order.
//   turkic_mode_we/turkic_mode_wdata write the Turkic mode bit (bit 0 kept);
//   write it only while no items are in flight.
// Path: from input accept to result valid through the input register, then the
//   result register fed by the mapping logic.
// Throughput: one item per cycle; both register stages advance together
//   whenever the result stage is empty or being taken.
// Stall: when m_axis_tready is low with a result waiting, the result stage holds,
//   the input stage still loads if empty, and s_axis_tready drops once it is full.
// Reset: rst (synchronous, active high) empties both stages and clears the
//   Turkic mode bit.
module unicode_lowercase_mapper import ulm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        turkic_mode_we,
  input  logic        turkic_mode_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] code_point
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [20:0] lower_code_point
);

  logic turkic_mode;
  logic in_valid;
  cp_t  in_cp;
  logic out_valid;
  cp_t  out_cp;
  cp_t  mapped;
  logic adv;

  assign adv = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_cp};

  // Hold the mode bit
  always_ff @(posedge clk) begin
    if (rst) turkic_mode <= 1'b0;
    else if (turkic_mode_we) turkic_mode <= turkic_mode_wdata;
  end

  ulm_core u_core (
    .cp_in            (turkic_mode),
    .code_point       (in_cp),
    .lower_code_point (mapped)
  );

  // Advance the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) out_valid <= in_valid;
      if (s_axis_tready) in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_cp <= mapped;
    if (s_axis_tready) in_cp <= s_axis_tdata[20:0];
  end

endmodule
